### rtl/stdr_pkg.sv
// Shared types, character codes and helpers for the script tag region detector.
package stdr_pkg;

    typedef enum logic [4:0] {
        ST_OUT_LT    = 5'd0,
        ST_OUT_S     = 5'd1,
        ST_OUT_C     = 5'd2,
        ST_OUT_R     = 5'd3,
        ST_OUT_I     = 5'd4,
        ST_OUT_P     = 5'd5,
        ST_OUT_T     = 5'd6,
        ST_OUT_WS_GT = 5'd7,
        ST_OUT_GT    = 5'd8,
        ST_IN_LT     = 5'd9,
        ST_IN_SLASH  = 5'd10,
        ST_IN_S      = 5'd11,
        ST_IN_C      = 5'd12,
        ST_IN_R      = 5'd13,
        ST_IN_I      = 5'd14,
        ST_IN_P      = 5'd15,
        ST_IN_T      = 5'd16,
        ST_IN_GT     = 5'd17
    } match_state_t;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_S     = 8'h73;
    localparam logic [7:0] CH_C     = 8'h63;
    localparam logic [7:0] CH_R     = 8'h72;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        if (c >= CH_UP_A && c <= CH_UP_Z)
        begin
            return c + CASE_GAP;
        end
        return c;
    endfunction

    function automatic logic is_inside(input match_state_t st);
        return (st >= ST_IN_LT) && (st <= ST_IN_GT);
    endfunction

endpackage

### rtl/script_tag_region_detector.sv
// Top level: byte-stream script tag region detector with input and result registers.
//
// One body byte is accepted per cycle unless out_ready stalls the output; its tagged copy
// passes the input register, then the result register. At full throughput one word is taken and
// one delivered every cycle. The figure is set by the single match-state register,
// whose next value is computed from the registered byte in one pass. Bytes are
// tagged passthrough or script region; the region starts after the '>' of an
// opening script tag and ends with the '>' of the closing tag. filter_enable may be
// written only while the block is idle; with it clear every byte passes through.
module script_tag_region_detector
    import stdr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       filter_enable_we,
    input  logic       filter_enable,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] body_byte,
    input  logic       body_start,
    input  logic       chunk_last,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       in_script,
    output logic       open_tag_done,
    output logic       script_done,
    output logic       flush_passthrough
);

    logic         enable_reg;
    match_state_t state_reg;
    match_state_t state_next;
    match_state_t cur_state;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_start_reg;
    logic       s1_last_reg;
    logic       s1_advance;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       in_script_reg;
    logic       open_done_reg;
    logic       script_done_reg;
    logic       flush_reg;

    logic [7:0] c;
    logic [7:0] lc;
    logic       in_script_next;
    logic       open_done_next;
    logic       script_done_next;
    logic       flush_next;
    match_state_t match_next;

    assign s1_advance = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    assign c         = s1_byte_reg;
    assign lc        = lower_ascii(s1_byte_reg);
    assign cur_state = s1_start_reg ? ST_OUT_LT : state_reg;

    always_comb
    begin
        match_next = ST_OUT_LT;
        case (cur_state)
            ST_OUT_LT:    match_next = (c == CH_LT) ? ST_OUT_S : ST_OUT_LT;
            ST_OUT_S:     match_next = (lc == CH_S) ? ST_OUT_C : ST_OUT_LT;
            ST_OUT_C:     match_next = (lc == CH_C) ? ST_OUT_R : ST_OUT_LT;
            ST_OUT_R:     match_next = (lc == CH_R) ? ST_OUT_I : ST_OUT_LT;
            ST_OUT_I:     match_next = (lc == CH_I) ? ST_OUT_P : ST_OUT_LT;
            ST_OUT_P:     match_next = (lc == CH_P) ? ST_OUT_T : ST_OUT_LT;
            ST_OUT_T:     match_next = (lc == CH_T) ? ST_OUT_WS_GT : ST_OUT_LT;
            ST_OUT_WS_GT:
            begin
                if (c == CH_GT)
                    match_next = ST_IN_LT;
                else if (c == CH_SPACE)
                    match_next = ST_OUT_GT;
                else
                    match_next = ST_OUT_LT;
            end
            ST_OUT_GT:    match_next = (c == CH_GT) ? ST_IN_LT : ST_OUT_GT;
            ST_IN_LT:     match_next = (c == CH_LT) ? ST_IN_SLASH : ST_IN_LT;
            ST_IN_SLASH:  match_next = (c == CH_SLASH) ? ST_IN_S : ST_IN_LT;
            ST_IN_S:      match_next = (lc == CH_S) ? ST_IN_C : ST_IN_LT;
            ST_IN_C:      match_next = (lc == CH_C) ? ST_IN_R : ST_IN_LT;
            ST_IN_R:      match_next = (lc == CH_R) ? ST_IN_I : ST_IN_LT;
            ST_IN_I:      match_next = (lc == CH_I) ? ST_IN_P : ST_IN_LT;
            ST_IN_P:      match_next = (lc == CH_P) ? ST_IN_T : ST_IN_LT;
            ST_IN_T:      match_next = (lc == CH_T) ? ST_IN_GT : ST_IN_LT;
            ST_IN_GT:     match_next = (c == CH_GT) ? ST_OUT_LT : ST_IN_LT;
            default:      match_next = ST_OUT_LT;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        if (s1_advance)
        begin
            state_next = enable_reg ? match_next : cur_state;
        end
    end

    always_comb
    begin
        in_script_next   = enable_reg && is_inside(cur_state);
        open_done_next   = enable_reg && (c == CH_GT)
                           && (cur_state == ST_OUT_WS_GT || cur_state == ST_OUT_GT);
        script_done_next = enable_reg && (c == CH_GT) && (cur_state == ST_IN_GT);
        flush_next       = s1_last_reg && (!enable_reg || !is_inside(match_next));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg    <= 1'b0;
            state_reg     <= ST_OUT_LT;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (filter_enable_we)
                enable_reg <= filter_enable;
            state_reg <= state_next;
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (!out_valid_reg || out_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= body_byte;
            s1_start_reg <= body_start;
            s1_last_reg  <= chunk_last;
        end
        if (s1_advance)
        begin
            out_byte_reg    <= c;
            in_script_reg   <= in_script_next;
            open_done_reg   <= open_done_next;
            script_done_reg <= script_done_next;
            flush_reg       <= flush_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;
    assign in_script         = in_script_reg;
    assign open_tag_done     = open_done_reg;
    assign script_done       = script_done_reg;
    assign flush_passthrough = flush_reg;

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the script tag region detector.
module testbench
    import stdr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned IDLE_LIMIT  = 3000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned REPORT_MAX  = 10;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       in_script;
        logic       open_tag_done;
        logic       script_done;
        logic       flush_passthrough;
    } tagged_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       filter_enable_we = 1'b0;
    logic       filter_enable = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] body_byte = 8'h00;
    logic       body_start = 1'b0;
    logic       chunk_last = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] out_byte;
    logic       in_script;
    logic       open_tag_done;
    logic       script_done;
    logic       flush_passthrough;

    // predictor copy of the block
    match_state_t tag_state = ST_OUT_LT;
    logic         filter_on = 1'b0;
    logic [7:0]   name_letters [6] = '{CH_S, CH_C, CH_R, CH_I, CH_P, CH_T};

    tagged_word_t tagged_q [$];
    int unsigned  mismatches = 0;
    int unsigned  words_sent = 0;
    int unsigned  idle_cycles = 0;
    int unsigned  rx_stall_left = 0;
    int unsigned  rx_pick;
    logic         rx_hold = 1'b0;
    logic         rx_steady = 1'b0;
    logic         tx_steady = 1'b0;
    logic         start_pending = 1'b0;

    script_tag_region_detector i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .filter_enable_we  (filter_enable_we),
        .filter_enable     (filter_enable),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .body_byte         (body_byte),
        .body_start        (body_start),
        .chunk_last        (chunk_last),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .in_script         (in_script),
        .open_tag_done     (open_tag_done),
        .script_done       (script_done),
        .flush_passthrough (flush_passthrough)
    );

    always #5 clk = ~clk;

    function automatic tagged_word_t tag_byte(input logic [7:0] c, input logic start,
                                              input logic last);
        tagged_word_t r;
        logic [7:0]   lc;
        match_state_t nx;
        r = '0;
        r.out_byte = c;
        lc = (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        if (start)
        begin
            tag_state = ST_OUT_LT;
        end
        if (!filter_on)
        begin
            r.flush_passthrough = last;
            return r;
        end
        nx = ST_OUT_LT;
        if (tag_state == ST_OUT_LT)
        begin
            nx = (c == CH_LT) ? ST_OUT_S : ST_OUT_LT;
        end
        else if (tag_state >= ST_OUT_S && tag_state <= ST_OUT_T)
        begin
            if (lc == name_letters[3'(tag_state - ST_OUT_S)])
                nx = match_state_t'(tag_state + 1);
        end
        else if (tag_state == ST_OUT_WS_GT || tag_state == ST_OUT_GT)
        begin
            if (c == CH_GT)
            begin
                nx = ST_IN_LT;
                r.open_tag_done = 1'b1;
            end
            else if (tag_state == ST_OUT_GT || c == CH_SPACE)
                nx = ST_OUT_GT;
        end
        else if (tag_state >= ST_IN_LT && tag_state <= ST_IN_GT)
        begin
            r.in_script = 1'b1;
            nx = ST_IN_LT;
            if (tag_state == ST_IN_LT)
            begin
                if (c == CH_LT)
                    nx = ST_IN_SLASH;
            end
            else if (tag_state == ST_IN_SLASH)
            begin
                if (c == CH_SLASH)
                    nx = ST_IN_S;
            end
            else if (tag_state < ST_IN_GT)
            begin
                if (lc == name_letters[3'(tag_state - ST_IN_S)])
                    nx = match_state_t'(tag_state + 1);
            end
            else if (c == CH_GT)
            begin
                nx = ST_OUT_LT;
                r.script_done = 1'b1;
            end
        end
        tag_state = nx;
        r.flush_passthrough = last && (nx < ST_IN_LT);
        return r;
    endfunction

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // sender: one word per call, payload held until accepted
    task automatic send_word(input logic [7:0] c, input logic start, input logic last);
        int unsigned gap;
        gap = tx_steady ? 0 : gap_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        body_byte  <= c;
        body_start <= start;
        chunk_last <= last;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        tagged_q.push_back(tag_byte(c, start, last));
        words_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tagged_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_filter(input logic v);
        wait_drained();
        filter_enable_we <= 1'b1;
        filter_enable    <= v;
        @(posedge clk);
        filter_enable_we <= 1'b0;
        filter_on = v;
    endtask

    function automatic logic [7:0] mix_case(input logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7A && $urandom_range(0, 1) == 1)
            return c - 8'h20;
        return c;
    endfunction

    function automatic logic [7:0] text_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return 8'($urandom_range(8'h20, 8'h7E));
        if (r == 7)
            return CH_LT;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] c);
        send_word(c, start_pending, $urandom_range(0, 7) == 0);
        start_pending = 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(mix_case(8'(s[i])));
    endtask

    task automatic send_fixed(input string s, input logic last_at_end);
        for (int i = 0; i < s.len(); i++)
            send_word(8'(s[i]), 1'b0, last_at_end && (i == s.len() - 1));
    endtask

    task automatic send_open_tag();
        int unsigned n;
        send_text("<script");
        if ($urandom_range(0, 1) == 1)
        begin
            send_byte(CH_SPACE);
            n = $urandom_range(0, 6);
            repeat (n) send_byte(text_byte());
        end
        send_byte(CH_GT);
    endtask

    task automatic send_script_body();
        int unsigned n;
        n = $urandom_range(0, 20);
        repeat (n) send_byte(text_byte());
    endtask

    // mostly well-formed script blocks, some truncated tags and noise
    task automatic send_html_block();
        int unsigned n;
        int unsigned k;
        string       tag_text;
        if ($urandom_range(0, 9) == 0)
            start_pending = 1'b1;
        n = $urandom_range(0, 8);
        repeat (n) send_byte(text_byte());
        k = $urandom_range(0, 9);
        if (k < 6)
        begin
            send_open_tag();
            send_script_body();
            send_text("</script>");
        end
        else if (k < 8)
        begin
            tag_text = "<script ";
            send_text(tag_text.substr(0, $urandom_range(0, 6)));
            send_byte(8'($urandom_range(0, 255)));
        end
        else if (k < 9)
        begin
            send_open_tag();
            send_script_body();
            tag_text = "</script>";
            send_text(tag_text.substr(0, $urandom_range(0, 7)));
            send_byte(8'($urandom_range(0, 255)));
            send_text("</script>");
        end
        else
        begin
            n = $urandom_range(1, 6);
            repeat (n) send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic send_html(input int unsigned count);
        int unsigned stop;
        stop = words_sent + count;
        while (words_sent < stop)
            send_html_block();
    endtask

    task automatic test_reset_passthrough();
        send_word(8'h00, 1'b1, 1'b1);
        send_fixed("<script>", 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        wait_drained();
    endtask

    task automatic test_directed_tags();
        write_filter(1'b1);
        send_fixed("<SCRIPT a>", 1'b1);
        send_word(8'hFF, 1'b0, 1'b1);
        send_fixed("</scr", 1'b0);
        send_word(8'h00, 1'b1, 1'b1);
        wait_drained();
    endtask

    task automatic test_random_html();
        tx_steady = 1'b1;
        rx_steady <= 1'b1;
        send_html(200);
        tx_steady = 1'b0;
        rx_steady <= 1'b0;
        send_html(900);
        wait_drained();
    endtask

    task automatic test_filter_toggle();
        write_filter(1'b0);
        send_html(50);
        write_filter(1'b1);
        send_html(50);
        write_filter(1'b0);
        send_html(50);
        write_filter(1'b1);
        send_html(50);
        wait_drained();
    endtask

    task automatic test_backpressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        tx_steady = 1'b1;
        send_html(60);
        tx_steady = 1'b0;
        wait_drained();
        send_html(60);
        wait_drained();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_passthrough();
        test_directed_tags();
        test_random_html();
        test_filter_toggle();
        test_backpressure();
        wait_drained();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && tagged_q.size() == 0)
        begin
            $display("script_tag_region_detector verification clean");
        end
        else
        begin
            $display("script_tag_region_detector verification failed");
        end
        $finish;
    end

    // receiver: random stalls, steady stretches, long hold on request
    always @(posedge clk)
    begin
        if (rx_hold || !rst_n)
            out_ready <= 1'b0;
        else if (rx_stall_left != 0)
        begin
            out_ready <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end
        else if (rx_steady)
            out_ready <= 1'b1;
        else
        begin
            rx_pick = $urandom_range(0, 99);
            if (rx_pick < 70)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                rx_stall_left <= gap_len();
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (tagged_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected word: byte %02h", out_byte);
            end
            else
            begin
                if (out_byte !== tagged_q[0].out_byte
                    || in_script !== tagged_q[0].in_script
                    || open_tag_done !== tagged_q[0].open_tag_done
                    || script_done !== tagged_q[0].script_done
                    || flush_passthrough !== tagged_q[0].flush_passthrough)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                    begin
                        $write("mismatch: exp byte %02h scr %b open %b done %b flush %b, ",
                               tagged_q[0].out_byte, tagged_q[0].in_script,
                               tagged_q[0].open_tag_done, tagged_q[0].script_done,
                               tagged_q[0].flush_passthrough);
                        $display("got byte %02h scr %b open %b done %b flush %b",
                                 out_byte, in_script, open_tag_done, script_done,
                                 flush_passthrough);
                    end
                end
                void'(tagged_q.pop_front());
            end
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("script_tag_region_detector verification failed");
                $finish;
            end
        end
    end

endmodule
